[rtl/core/linear_probe_hash_set_core_defines.svh]
// assertion macros for the linear probe hash set core
// used by linear_probe_hash_set_core; expects clk and rst in scope
`ifndef LINEAR_PROBE_HASH_SET_CORE_DEFINES_SVH
`define LINEAR_PROBE_HASH_SET_CORE_DEFINES_SVH

// same-cycle implication
`define LPHS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lphs assertion failed");

// next-cycle implication
`define LPHS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lphs assertion failed");

`endif

[rtl/core/lphs_pkg.sv]
// types, constants and helpers of the linear probe hash set core
// no dependencies; imported by every module of the core
package lphs_pkg;

  // slot count, a power of two
  localparam int TABLE_SLOTS  = 512;
  localparam int SLOT_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int KEY_W        = 32;
  localparam int SLOT_FIELD_W = 9;

  localparam logic [KEY_W-1:0] HASH_MULT = 32'd2654435761;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TABLE_SLOTS - 1);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_PRESENT   = 3'd3,
    ST_ABSENT    = 3'd4,
    ST_CLEARED   = 3'd5
  } status_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [KEY_W-1:0] key;
  } in_t;

  typedef struct packed {
    status_t                 status;
    logic [SLOT_FIELD_W-1:0] slot;
  } out_t;

  // classified word passed from front to back
  typedef struct packed {
    cmd_t              cmd;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] home;
  } job_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
  } entry_t;

  function automatic logic [SLOT_FIELD_W-1:0] slot_field(input logic [SLOT_W-1:0] idx);
    slot_field = SLOT_FIELD_W'(idx);
  endfunction

endpackage

[rtl/core/linear_probe_hash_set_core.sv]
// linear probe hash set core: front, queue and back joined; needs lphs_pkg and the defines header
// flow: the front registers each word and the queue holds it until the back takes it in S_IDLE;
// insert and lookup probe in S_PROBE, clear sweeps in S_CLEAR, and S_DONE registers the result
// the back works on one job at a time, its single table read port probing one slot a cycle
// reset: an init sweep empties the table; in_ready stays low meanwhile
`include "linear_probe_hash_set_core_defines.svh"
module linear_probe_hash_set_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  lphs_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output lphs_pkg::out_t out_data
);
  import lphs_pkg::*;

  logic init_busy;
  logic push_valid;
  logic push_ready;
  job_t push_data;
  logic q_valid;
  logic q_pop;
  job_t q_data;
  logic zero_slot_word;

  lphs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .hold       (init_busy),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  lphs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  lphs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_data    (q_data),
    .init_busy (init_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign zero_slot_word = (out_data.status == ST_FULL) || (out_data.status == ST_ABSENT) ||
                          (out_data.status == ST_CLEARED);

  `LPHS_ASSERT_IMP(a_no_accept_in_init, init_busy, !in_ready)
  `LPHS_ASSERT_IMP(a_no_word_in_init, init_busy, !out_valid)
  `LPHS_ASSERT_NXT(a_init_done_once, in_valid && in_ready, !init_busy)
  `LPHS_ASSERT_IMP(a_zero_slot, out_valid && zero_slot_word, out_data.slot == '0)

endmodule

[rtl/core/lphs_front.sv]
// front end: accepts input words and computes the home slot
// depends on lphs_pkg
module lphs_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           hold,
  input  logic           in_valid,
  output logic           in_ready,
  input  lphs_pkg::in_t  in_data,
  output logic           push_valid,
  input  logic           push_ready,
  output lphs_pkg::job_t push_data
);
  import lphs_pkg::*;

  logic                  fv;
  job_t                  fjob;
  logic [2*KEY_W-1:0]    prod;

  assign prod       = (2*KEY_W)'(in_data.key) * (2*KEY_W)'(HASH_MULT);
  assign in_ready   = !hold && (!fv || push_ready);
  assign push_valid = fv;
  assign push_data  = fjob;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (in_valid && in_ready) begin
      fv        <= 1'b1;
      fjob.cmd  <= in_data.cmd;
      fjob.key  <= in_data.key;
      fjob.home <= prod[SLOT_W-1:0];
    end else if (push_ready) begin
      fv <= 1'b0;
    end
  end

endmodule

[rtl/core/lphs_queue.sv]
// two-entry queue between front and back
// depends on lphs_pkg
module lphs_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  lphs_pkg::job_t push_data,
  output logic           pop_valid,
  input  logic           pop,
  output lphs_pkg::job_t pop_data
);
  import lphs_pkg::*;

  job_t       q [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = q[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= !wptr;
      end
      if (do_pop) begin
        rptr <= !rptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

[rtl/core/lphs_back.sv]
// back end: slot table, probe sequencer, clear sweep and output register
// depends on lphs_pkg
module lphs_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_pop,
  input  lphs_pkg::job_t q_data,
  output logic           init_busy,
  output logic           out_valid,
  input  logic           out_ready,
  output lphs_pkg::out_t out_data
);
  import lphs_pkg::*;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_PROBE,
    S_CLEAR,
    S_DONE
  } state_t;

  state_t            state;
  job_t              job;
  out_t              res;
  logic [SLOT_W-1:0] idx;
  logic [SLOT_W-1:0] cnt;

  entry_t            mem [TABLE_SLOTS];
  entry_t            rdata;
  logic              we;
  logic [SLOT_W-1:0] waddr;
  entry_t            wdata;
  logic [SLOT_W-1:0] raddr;
  logic              hit;
  logic              last;

  assign hit       = rdata.valid && (rdata.key == job.key);
  assign last      = (cnt == SLOT_LAST);
  assign q_pop     = (state == S_IDLE) && q_valid;
  assign init_busy = (state == S_INIT);

  always_comb begin
    we          = 1'b0;
    waddr       = idx;
    wdata.valid = 1'b0;
    wdata.key   = '0;
    raddr       = idx;
    unique case (state)
      S_INIT, S_CLEAR: begin
        we = 1'b1;
      end
      S_IDLE: begin
        raddr = q_data.home;
      end
      S_PROBE: begin
        if (!rdata.valid) begin
          if (job.cmd == CMD_INSERT) begin
            we          = 1'b1;
            wdata.valid = 1'b1;
            wdata.key   = job.key;
          end
        end else if (!hit && !last) begin
          raddr = idx + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          idx <= idx + 1'b1;
          if (idx == SLOT_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            job <= q_data;
            cnt <= '0;
            unique case (q_data.cmd)
              CMD_INSERT, CMD_LOOKUP: begin
                idx   <= q_data.home;
                state <= S_PROBE;
              end
              CMD_CLEAR: begin
                idx   <= '0;
                state <= S_CLEAR;
              end
              default: begin
                res.status <= ST_ABSENT;
                res.slot   <= '0;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_PROBE: begin
          priority if (!rdata.valid) begin
            if (job.cmd == CMD_INSERT) begin
              res.status <= ST_INSERTED;
              res.slot   <= slot_field(idx);
            end else begin
              res.status <= ST_ABSENT;
              res.slot   <= '0;
            end
            state <= S_DONE;
          end else if (hit) begin
            res.status <= (job.cmd == CMD_INSERT) ? ST_DUPLICATE : ST_PRESENT;
            res.slot   <= slot_field(idx);
            state      <= S_DONE;
          end else if (last) begin
            res.status <= (job.cmd == CMD_INSERT) ? ST_FULL : ST_ABSENT;
            res.slot   <= '0;
            state      <= S_DONE;
          end else begin
            idx <= idx + 1'b1;
            cnt <= cnt + 1'b1;
          end
        end
        S_CLEAR: begin
          idx <= idx + 1'b1;
          if (idx == SLOT_LAST) begin
            res.status <= ST_CLEARED;
            res.slot   <= '0;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data  <= res;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
